>>> sv/anfd_pkg.sv
package anfd_pkg;

  localparam int unsigned FrameDataBytes = 8;
  localparam int unsigned PredShift      = 11;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned AccW           = 2 * SampleW;
  localparam int unsigned CntW           = 4;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0]    acc_t;

  // MAC control: en loads the accumulator, clr restarts the sum
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

  function automatic sample_t coef_c1(input logic [3:0] idx);
    sample_t c;
    case (idx)
      4'd0:    c = 16'sh0000;
      4'd1:    c = 16'sh0800;
      4'd2:    c = 16'sh0000;
      4'd3:    c = 16'sh0400;
      4'd4:    c = 16'sh1000;
      4'd5:    c = 16'sh0E00;
      4'd6:    c = 16'sh0C00;
      4'd7:    c = 16'sh1200;
      4'd8:    c = 16'sh1068;
      4'd9:    c = 16'sh12C0;
      4'd10:   c = 16'sh1400;
      4'd11:   c = 16'sh0800;
      4'd12:   c = 16'sh0400;
      4'd13:   c = 16'shFC00;
      4'd14:   c = 16'shFC00;
      4'd15:   c = 16'shF800;
      default: c = 16'sh0000;
    endcase
    return c;
  endfunction

  function automatic sample_t coef_c2(input logic [3:0] idx);
    sample_t c;
    case (idx)
      4'd0:    c = 16'sh0000;
      4'd1:    c = 16'sh0000;
      4'd2:    c = 16'sh0800;
      4'd3:    c = 16'sh0400;
      4'd4:    c = 16'shF800;
      4'd5:    c = 16'shFA00;
      4'd6:    c = 16'shFC00;
      4'd7:    c = 16'shF600;
      4'd8:    c = 16'shF738;
      4'd9:    c = 16'shF704;
      4'd10:   c = 16'shF400;
      4'd11:   c = 16'shF800;
      4'd12:   c = 16'shFC00;
      4'd13:   c = 16'sh0400;
      4'd14:   c = 16'sh0000;
      4'd15:   c = 16'sh0000;
      default: c = 16'sh0000;
    endcase
    return c;
  endfunction

  // nibble scaled by the frame shift plus the floored prediction, wrapped to 16 bits
  function automatic sample_t calc_sample(input logic [3:0] nib, input logic [3:0] shift,
                                          input acc_t acc);
    logic [SampleW-1:0] ext;
    logic [SampleW-1:0] scaled;
    ext    = {{(SampleW-4){nib[3]}}, nib};
    scaled = ext << shift;
    return sample_t'(scaled + acc[PredShift +: SampleW]);
  endfunction

endpackage

>>> sv/anfd_if.sv
interface anfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       clear_history;
  logic       block_end;

  modport source (output valid, output data_byte, output clear_history, output block_end,
                  input ready);
  modport sink (input valid, input data_byte, input clear_history, input block_end,
                output ready);
endinterface

interface anfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_first;
  logic signed [15:0] sample_second;
  logic               channel;

  modport source (output valid, output sample_first, output sample_second, output channel,
                  input ready);
  modport sink (input valid, input sample_first, input sample_second, input channel,
                output ready);
endinterface

>>> sv/anfd_mac.sv
module anfd_mac import anfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  sample_t   a_i,
  input  sample_t   b_i,
  output acc_t      acc_o
);

  acc_t prod;
  acc_t acc_d, acc_q;

  assign prod  = acc_t'(a_i) * acc_t'(b_i);
  assign acc_d = (ctrl_i.clr ? '0 : acc_q) + prod;
  assign acc_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> sv/adpcm_nibble_frame_decoder.sv
// ADPCM frame decoder: 9-byte frames (header + 8 data bytes), two samples per data byte.
// in_i carries one compressed byte per word, with clear_history and block_end flags.
// A header byte is absorbed in the idle state and gives no output word. A data byte gives
// one output word on out_o: both samples and the channel they belong to.
// A data byte steps through S_M1, S_M2, S_F1, S_M3, S_M4 and S_F2 into the output register.
// in_i.ready is low while the byte runs through the sequencer, so no new byte is taken
// until it is done. The sequencer uses a single 16x16 multiply-accumulate unit four
// times (c1*recent, c2*older, then c1*first, c2*recent) with a sample add after
// each pair.
// User must write stereo_mode via cfg_we_i/cfg_data_i only while idle (not enforced).
// Reset sets stereo_mode to 1 and clears both channel histories, the frame position
// (next byte is a left header) and the output register.
// The output register lets the next byte be taken while a word waits on out_o;
// if it is still full when the next result is ready, the sequencer holds until
// out_o.ready frees it.
module adpcm_nibble_frame_decoder import anfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_data_i,
  anfd_in_if.sink    in_i,
  anfd_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_M1, S_M2, S_F1, S_M3, S_M4, S_F2
  } state_e;

  state_e          state_q;
  logic            stereo_q;
  sample_t         recent_q [2];
  sample_t         older_q  [2];
  logic [3:0]      shift_q;
  logic [3:0]      coef_q;
  logic [CntW-1:0] bif_q;
  logic            chan_q;
  logic            ch_q;
  logic [7:0]      byte_q;
  sample_t         wr_q, wo_q, s1_q;
  logic            out_valid_q;
  sample_t         out_first_q, out_second_q;
  logic            out_ch_q;

  logic            in_acc;
  logic [CntW-1:0] bif_eff;
  logic            ch_eff;
  logic            load_out;
  mac_ctrl_t       mac_ctrl;
  sample_t         mac_a, mac_b;
  acc_t            acc;
  sample_t         s_new;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign bif_eff    = in_i.clear_history ? '0 : bif_q;
  assign ch_eff     = in_i.clear_history ? 1'b0 : chan_q;
  assign load_out   = (state_q == S_F2) && (!out_valid_q || out_o.ready);

  always_comb begin
    mac_ctrl.en  = 1'b0;
    mac_ctrl.clr = 1'b0;
    mac_a        = coef_c1(coef_q);
    mac_b        = wr_q;
    case (state_q)
      S_M1: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = 1'b1;
      end
      S_M2: begin
        mac_ctrl.en = 1'b1;
        mac_a       = coef_c2(coef_q);
        mac_b       = wo_q;
      end
      S_M3: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = 1'b1;
        mac_b        = s1_q;
      end
      S_M4: begin
        mac_ctrl.en = 1'b1;
        mac_a       = coef_c2(coef_q);
      end
      default: ;
    endcase
  end

  anfd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // high nibble in the first pass, low nibble in the second
  assign s_new = calc_sample((state_q == S_F1) ? byte_q[7:4] : byte_q[3:0], shift_q, acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      stereo_q     <= 1'b1;
      recent_q[0]  <= '0;
      recent_q[1]  <= '0;
      older_q[0]   <= '0;
      older_q[1]   <= '0;
      shift_q      <= '0;
      coef_q       <= '0;
      bif_q        <= '0;
      chan_q       <= 1'b0;
      ch_q         <= 1'b0;
      byte_q       <= '0;
      wr_q         <= '0;
      wo_q         <= '0;
      s1_q         <= '0;
      out_valid_q  <= 1'b0;
      out_first_q  <= '0;
      out_second_q <= '0;
      out_ch_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stereo_q <= cfg_data_i;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.clear_history) begin
              recent_q[0] <= '0;
              recent_q[1] <= '0;
              older_q[0]  <= '0;
              older_q[1]  <= '0;
            end
            chan_q <= ch_eff;
            if (bif_eff == '0) begin
              shift_q <= in_i.data_byte[7:4];
              coef_q  <= in_i.data_byte[3:0];
              bif_q   <= CntW'(1);
            end else begin
              byte_q  <= in_i.data_byte;
              ch_q    <= ch_eff;
              wr_q    <= recent_q[ch_eff];
              wo_q    <= older_q[ch_eff];
              state_q <= S_M1;
              if (bif_eff >= CntW'(FrameDataBytes)) begin
                bif_q  <= '0;
                chan_q <= stereo_q && !ch_eff;
              end else begin
                bif_q <= bif_eff + CntW'(1);
              end
            end
            // block end overrides the frame position: next byte is a left header
            if (in_i.block_end) begin
              bif_q  <= '0;
              chan_q <= 1'b0;
            end
          end
        end
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_F1;
        S_F1: begin
          s1_q    <= s_new;
          state_q <= S_M3;
        end
        S_M3: state_q <= S_M4;
        S_M4: state_q <= S_F2;
        S_F2: begin
          // hold until the output register is free
          if (load_out) begin
            out_valid_q      <= 1'b1;
            out_first_q      <= s1_q;
            out_second_q     <= s_new;
            out_ch_q         <= ch_q;
            older_q[ch_q]    <= s1_q;
            recent_q[ch_q]   <= s_new;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_first  = out_first_q;
  assign out_o.sample_second = out_second_q;
  assign out_o.channel       = out_ch_q;

  a_bif_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bif_q <= CntW'(FrameDataBytes))
    else $error("frame position beyond the last data byte");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && bif_eff != '0) |=> !in_i.ready)
    else $error("ready stayed high after a data byte was taken");

  a_load_from_f2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_F2))
    else $error("output word loaded outside the final sequencer step");

  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && bif_eff == '0) |=> in_i.ready)
    else $error("header byte did not return to idle");

endmodule
